### rtl/pngsd_pkg.sv
// shared types, constants and functions of the stored-deflate png encoder
package pngsd_pkg;

	localparam int MaxSideDefault = 4096;
	localparam logic [31:0] CrcPoly = 32'hEDB88320;
	localparam logic [31:0] CrcAll = 32'hFFFFFFFF;
	localparam logic [16:0] AdlerMod = 17'd65521;
	localparam logic [15:0] BlockMax = 16'hFFFF;

	localparam logic [0:0] RegWidth = 1'b0;
	localparam logic [0:0] RegHeight = 1'b1;

	localparam logic [0:0] ModePixel = 1'b0;
	localparam logic [0:0] ModeFinish = 1'b1;

	// work item handed from the front to the back
	typedef enum logic [1:0] {
		JOB_ERROR,
		JOB_PIXEL,
		JOB_FINISH
	} job_kind_t;

	typedef struct packed {
		job_kind_t kind;
		logic open_hdr;
		logic row_start;
		logic [23:0] rgb;
		logic [12:0] width;
		logic [12:0] height;
		logic [25:0] raw_len;
		logic [31:0] idat_len;
	} job_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_HDR,
		ST_BHDR,
		ST_RAW,
		ST_ADLER,
		ST_TRAIL,
		ST_ERR
	} bk_state_t;

	// one byte through the reflected crc-32
	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		for (int k = 0; k < 8; k++)
			r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
		return r;
	endfunction

endpackage

### rtl/pngsd_front.sv
// front end: sequence tracking, classification and frame size math
module pngsd_front import pngsd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [0:0] cfg_idx,
	input logic [12:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input logic mode,
	input logic [23:0] pixel_rgb,
	output logic job_valid,
	input logic job_stall,
	output job_t job
);

	localparam logic [12:0] MaxSide13 = 13'(MaxSideDefault);

	logic [12:0] width_q, height_q, eff_w, eff_h;
	logic frame_open_q, complete_q;
	logic [12:0] col_q, row_q;
	logic [25:0] raw_len_q;
	logic [31:0] idat_len_q;
	logic [25:0] row_bytes_q;
	logic [1:0] calc_q;
	logic take;
	job_t job_d;

	function automatic logic [12:0] clamp(input logic [12:0] v);
		if (v == 13'd0) return 13'd1;
		if (v > MaxSide13) return MaxSide13;
		return v;
	endfunction

	assign eff_w = clamp(width_q);
	assign eff_h = clamp(height_q);

	// sizes are recomputed after reset and after each config write; input stalls meanwhile
	assign in_stall = (job_valid && job_stall) || (calc_q != 2'd0);
	assign take = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 13'd1;
			height_q <= 13'd1;
			calc_q <= 2'd3;
		end else begin
			if (cfg_we && !frame_open_q) begin
				if (cfg_idx == RegWidth) width_q <= cfg_data;
				else height_q <= cfg_data;
				calc_q <= 2'd3;
			end else if (calc_q != 2'd0) begin
				calc_q <= calc_q - 2'd1;
			end
		end
	end

	// idat length: 2 + raw + 5*ceil(raw/65535) + 4
	logic [25:0] nblk;
	always_comb begin
		logic [25:0] t;
		t = raw_len_q + 26'(BlockMax) - 26'd1;
		// ceil by reciprocal: floor(x/65535) for x < 2^26 - 1024
		nblk = 26'((t + (t >> 16) + 26'd1) >> 16);
	end

	always_ff @(posedge clk) begin
		row_bytes_q <= 26'd1 + 26'd3 * 26'(eff_w);
		raw_len_q <= 26'(row_bytes_q * 26'(eff_h));
		idat_len_q <= 32'd6 + 32'(raw_len_q) + 32'd5 * 32'(nblk);
	end

	always_comb begin
		job_d = '0;
		job_d.rgb = pixel_rgb;
		job_d.width = eff_w;
		job_d.height = eff_h;
		job_d.raw_len = raw_len_q;
		job_d.idat_len = idat_len_q;
		job_d.open_hdr = !frame_open_q;
		job_d.row_start = !frame_open_q || (col_q == 13'd0);
		if (mode == ModePixel)
			job_d.kind = (frame_open_q && complete_q) ? JOB_ERROR : JOB_PIXEL;
		else
			job_d.kind = (frame_open_q && complete_q) ? JOB_FINISH : JOB_ERROR;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_open_q <= 1'b0;
			complete_q <= 1'b0;
			col_q <= 13'd0;
			row_q <= 13'd0;
			job_valid <= 1'b0;
		end else begin
			if (job_valid && !job_stall) job_valid <= 1'b0;
			if (take) begin
				job_valid <= 1'b1;
				if (job_d.kind == JOB_PIXEL) begin
					frame_open_q <= 1'b1;
					if (col_q + 13'd1 >= eff_w) begin
						col_q <= 13'd0;
						if (row_q + 13'd1 >= eff_h) begin
							row_q <= 13'd0;
							complete_q <= 1'b1;
						end else row_q <= row_q + 13'd1;
					end else col_q <= col_q + 13'd1;
				end else if (job_d.kind == JOB_FINISH) begin
					frame_open_q <= 1'b0;
					complete_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) job <= job_d;
	end

endmodule

### rtl/pngsd_back.sv
// back end: byte sequencer with crc and adler state
module pngsd_back import pngsd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic job_valid,
	output logic job_stall,
	input job_t job,
	output logic out_valid,
	input logic out_stall,
	output logic [7:0] out_byte,
	output logic last_of_run,
	output logic end_of_file,
	output logic error
);

	bk_state_t state_q, state_d;
	job_t job_q;
	logic [5:0] idx_q, idx_d;
	logic [2:0] sub_q, sub_d;
	logic [25:0] raw_rem_q;
	logic [15:0] blk_left_q;
	logic [15:0] adl_lo_q, adl_hi_q;
	logic [31:0] crc_q, ihdr_crc_q, ihdr_crc_d;
	logic [31:0] adler_w;

	// output holding register
	logic ov_q;
	logic [7:0] ob_q;
	logic ol_q, oe_q, oerr_q;
	logic emit, free;
	logic [7:0] b;
	logic last, eof, is_err, to_crc, is_raw, new_blk;
	logic [15:0] n16;

	assign free = !ov_q || !out_stall;
	assign out_valid = ov_q;
	assign out_byte = ob_q;
	assign last_of_run = ol_q;
	assign end_of_file = oe_q;
	assign error = oerr_q;
	assign job_stall = (state_q != ST_IDLE);
	assign adler_w = {adl_hi_q, adl_lo_q};
	assign n16 = (raw_rem_q > 26'(BlockMax)) ? BlockMax : raw_rem_q[15:0];

	// header bytes: signature, ihdr, ihdr crc, idat length, idat type, zlib header
	function automatic logic [7:0] hdr_byte(input logic [5:0] i, input job_t j,
		input logic [31:0] ic);
		logic [7:0] r;
		unique case (i)
			6'd0: r = 8'd137; 6'd1: r = "P"; 6'd2: r = "N"; 6'd3: r = "G";
			6'd4: r = 8'd13; 6'd5: r = 8'd10; 6'd6: r = 8'd26; 6'd7: r = 8'd10;
			6'd8, 6'd9, 6'd10: r = 8'd0; 6'd11: r = 8'd13;
			6'd12: r = "I"; 6'd13: r = "H"; 6'd14: r = "D"; 6'd15: r = "R";
			6'd16, 6'd17: r = 8'd0;
			6'd18: r = {3'd0, j.width[12:8]}; 6'd19: r = j.width[7:0];
			6'd20, 6'd21: r = 8'd0;
			6'd22: r = {3'd0, j.height[12:8]}; 6'd23: r = j.height[7:0];
			6'd24: r = 8'd8; 6'd25: r = 8'd2;
			6'd26, 6'd27, 6'd28: r = 8'd0;
			6'd29: r = ic[31:24]; 6'd30: r = ic[23:16]; 6'd31: r = ic[15:8];
			6'd32: r = ic[7:0];
			6'd33: r = j.idat_len[31:24]; 6'd34: r = j.idat_len[23:16];
			6'd35: r = j.idat_len[15:8]; 6'd36: r = j.idat_len[7:0];
			6'd37: r = "I"; 6'd38: r = "D"; 6'd39: r = "A"; 6'd40: r = "T";
			6'd41: r = 8'h78; 6'd42: r = 8'h01;
			default: r = 8'd0;
		endcase
		return r;
	endfunction

	// trailer: idat crc, iend length, type and its fixed crc
	function automatic logic [7:0] trl_byte(input logic [4:0] i, input logic [31:0] c);
		logic [7:0] r;
		unique case (i)
			5'd0: r = c[31:24]; 5'd1: r = c[23:16]; 5'd2: r = c[15:8]; 5'd3: r = c[7:0];
			5'd4, 5'd5, 5'd6, 5'd7: r = 8'd0;
			5'd8: r = "I"; 5'd9: r = "E"; 5'd10: r = "N"; 5'd11: r = "D";
			5'd12: r = 8'hAE; 5'd13: r = 8'h42; 5'd14: r = 8'h60; 5'd15: r = 8'h82;
			default: r = 8'd0;
		endcase
		return r;
	endfunction

	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		sub_d = sub_q;
		emit = 1'b0;
		b = 8'd0;
		last = 1'b0;
		eof = 1'b0;
		is_err = 1'b0;
		to_crc = 1'b0;
		is_raw = 1'b0;
		new_blk = 1'b0;
		ihdr_crc_d = ihdr_crc_q;
		unique case (state_q)
			ST_IDLE: begin
				if (job_valid) begin
					idx_d = 6'd0;
					sub_d = 3'd0;
					if (job.open_hdr) ihdr_crc_d = CrcAll;
					if (job.kind == JOB_ERROR) state_d = ST_ERR;
					else if (job.kind == JOB_FINISH) state_d = ST_ADLER;
					else if (job.open_hdr) state_d = ST_HDR;
					else if (blk_left_q == 16'd0) state_d = ST_BHDR;
					else state_d = ST_RAW;
					sub_d = job.row_start ? 3'd0 : 3'd1;
				end
			end
			ST_ERR: if (free) begin
				emit = 1'b1; is_err = 1'b1; last = 1'b1; state_d = ST_IDLE;
			end
			ST_HDR: if (free) begin
				emit = 1'b1;
				b = hdr_byte(idx_q, job_q, ihdr_crc_q ^ CrcAll);
				to_crc = (idx_q >= 6'd37);
				if (idx_q >= 6'd12 && idx_q <= 6'd28)
					ihdr_crc_d = crc_byte(ihdr_crc_q, b);
				idx_d = idx_q + 6'd1;
				if (idx_q == 6'd42) begin
					idx_d = 6'd0;
					state_d = ST_BHDR;
				end
			end
			ST_BHDR: if (free) begin
				emit = 1'b1; to_crc = 1'b1;
				unique case (idx_q[2:0])
					3'd0: b = {7'd0, raw_rem_q <= 26'(BlockMax)};
					3'd1: b = n16[7:0];
					3'd2: b = n16[15:8];
					3'd3: b = ~n16[7:0];
					default: b = ~n16[15:8];
				endcase
				idx_d = idx_q + 6'd1;
				if (idx_q == 6'd4) begin
					new_blk = 1'b1; idx_d = 6'd0; state_d = ST_RAW;
				end
			end
			ST_RAW: if (free) begin
				emit = 1'b1; to_crc = 1'b1; is_raw = 1'b1;
				unique case (sub_q)
					3'd0: b = 8'd0;
					3'd1: b = job_q.rgb[7:0];
					3'd2: b = job_q.rgb[15:8];
					default: b = job_q.rgb[23:16];
				endcase
				sub_d = sub_q + 3'd1;
				if (sub_q == 3'd3) begin
					last = 1'b1; state_d = ST_IDLE;
				end else if (blk_left_q == 16'd1) state_d = ST_BHDR;
			end
			ST_ADLER: if (free) begin
				emit = 1'b1; to_crc = 1'b1;
				unique case (idx_q[1:0])
					2'd0: b = adler_w[31:24];
					2'd1: b = adler_w[23:16];
					2'd2: b = adler_w[15:8];
					default: b = adler_w[7:0];
				endcase
				idx_d = idx_q + 6'd1;
				if (idx_q == 6'd3) begin
					idx_d = 6'd0; state_d = ST_TRAIL;
				end
			end
			ST_TRAIL: if (free) begin
				emit = 1'b1;
				b = trl_byte(idx_q[4:0], crc_q ^ CrcAll);
				idx_d = idx_q + 6'd1;
				if (idx_q == 6'd15) begin
					last = 1'b1; eof = 1'b1; state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= 6'd0;
			sub_q <= 3'd0;
			ov_q <= 1'b0;
			raw_rem_q <= 26'd0;
			blk_left_q <= 16'd0;
			adl_lo_q <= 16'd1;
			adl_hi_q <= 16'd0;
			crc_q <= CrcAll;
			ihdr_crc_q <= CrcAll;
		end else begin
			state_q <= state_d;
			idx_q <= idx_d;
			sub_q <= sub_d;
			ihdr_crc_q <= ihdr_crc_d;
			if (emit) ov_q <= 1'b1;
			else if (!out_stall) ov_q <= 1'b0;
			if (state_q == ST_IDLE && job_valid && job.open_hdr && job.kind == JOB_PIXEL)
				begin
				raw_rem_q <= job.raw_len;
				blk_left_q <= 16'd0;
				adl_lo_q <= 16'd1;
				adl_hi_q <= 16'd0;
				crc_q <= CrcAll;
			end
			if (to_crc) crc_q <= crc_byte(crc_q, b);
			if (new_blk) blk_left_q <= n16;
			if (is_raw) begin
				logic [16:0] lo, hi;
				lo = 17'(adl_lo_q) + 17'(b);
				if (lo >= AdlerMod) lo = lo - AdlerMod;
				hi = 17'(adl_hi_q) + lo;
				if (hi >= AdlerMod) hi = hi - AdlerMod;
				adl_lo_q <= lo[15:0];
				adl_hi_q <= hi[15:0];
				blk_left_q <= blk_left_q - 16'd1;
				raw_rem_q <= raw_rem_q - 26'd1;
			end
			if (state_q == ST_TRAIL && emit && eof) begin
				raw_rem_q <= 26'd0;
				blk_left_q <= 16'd0;
				adl_lo_q <= 16'd1;
				adl_hi_q <= 16'd0;
				crc_q <= CrcAll;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && job_valid) job_q <= job;
		if (emit) begin
			ob_q <= b;
			ol_q <= last;
			oe_q <= eof;
			oerr_q <= is_err;
		end
	end

endmodule

### rtl/png_stored_deflate_encoder_unit.sv
// top level of the stored-deflate png encoder
// Streams a complete uncompressed RGB8 PNG file, one byte per output transfer.
// A pixel transfer gives 3 bytes (4 at a row start, plus 5 for each stored block
// header due); the first pixel of a frame adds 43 header bytes, a finish gives
// 20 trailer bytes, a misplaced item gives one error byte. The byte sequencer
// in the back end emits one byte per cycle while the output does not stall,
// and it picks up each job in its idle state before the first byte of the job;
// it takes no new job until it is through with the last one. The front end
// classifies the next item while the back end works, through a one-entry job
// register. After reset or a size register write the front end recomputes the
// row length, raw length and idat length in turn and stalls input until they
// are done. Size registers write only while no frame is open; sizes are clamped
// to 1..4096.
module png_stored_deflate_encoder_unit import pngsd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [0:0] cfg_idx,
	input logic [12:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input logic mode,
	input logic [23:0] pixel_rgb,
	output logic out_valid,
	input logic out_stall,
	output logic [7:0] out_byte,
	output logic last_of_run,
	output logic end_of_file,
	output logic error
);

	logic job_valid, job_stall;
	job_t job;

	pngsd_front u_front (
		.clk, .arst_n, .cfg_we, .cfg_idx, .cfg_data, .in_valid, .in_stall,
		.mode, .pixel_rgb, .job_valid, .job_stall, .job
	);

	pngsd_back u_back (
		.clk, .arst_n, .job_valid, .job_stall, .job, .out_valid, .out_stall,
		.out_byte, .last_of_run, .end_of_file, .error
	);

	// an error byte always ends its run
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error |-> last_of_run) else $error("error without last");
	// end of file is the last byte of a run
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_of_file |-> last_of_run && !error) else $error("bad eof");

endmodule
